FILE: sv/kwm_pkg.sv
// Shared types and constants for the k-way sorted merge core.
package kwm_pkg;

    // Sizing
    localparam int LISTS  = 8;
    localparam int DEPTH  = 64;
    localparam int LIST_W = $clog2(LISTS);
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int HEAD_W = $clog2(DEPTH + 1);
    localparam int WORDS  = LISTS << SLOT_W;
    localparam int ADDR_W = LIST_W + SLOT_W;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    // Item modes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        list_index;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
    } t_out_item;

    // Pointer table update command
    typedef struct packed {
        logic              clear;
        logic              fill_inc;
        logic              head_wr;
        logic [LIST_W-1:0] head_idx;
        logic [HEAD_W-1:0] head_val;
    } t_ptr_cmd;

    // One candidate head entering the compare stage
    typedef struct packed {
        logic              valid;
        logic [LIST_W-1:0] idx;
        logic [HEAD_W-1:0] head;
    } t_cand;

    // Running minimum over the scan
    typedef struct packed {
        logic                     found;
        logic [LIST_W-1:0]        idx;
        logic [HEAD_W-1:0]        head;
        logic signed [DATA_W-1:0] value;
    } t_best;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage

FILE: sv/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/kwm_ptrs.sv
// Per-list fill and head counters with one shared read index.
module kwm_ptrs
    import kwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LIST_W-1:0] i_rd_idx,
    input  t_ptr_cmd          i_cmd,
    output logic [HEAD_W-1:0] o_fill,
    output logic [HEAD_W-1:0] o_head
);

    logic [HEAD_W-1:0] r_fill [LISTS];
    logic [HEAD_W-1:0] r_head [LISTS];
    logic              in_range;

    assign in_range = (32'(i_rd_idx) < LISTS);

    // Index codes beyond the list count read as empty
    assign o_fill = in_range ? r_fill[i_rd_idx] : '0;
    assign o_head = in_range ? r_head[i_rd_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int l = 0; l < LISTS; l++) begin
                r_fill[l] <= '0;
                r_head[l] <= '0;
            end
        end else begin
            // Append bumps the fill of the list being read
            if (i_cmd.fill_inc && in_range) begin
                r_fill[i_rd_idx] <= r_fill[i_rd_idx] + HEAD_W'(1);
            end
            if (i_cmd.head_wr) begin
                r_head[i_cmd.head_idx] <= i_cmd.head_val;
            end
        end
    end

endmodule

FILE: sv/kwm_minsel.sv
// Shared signed comparator tracking the smallest head over a scan.
module kwm_minsel
    import kwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_cand             i_cand,
    input  logic [DATA_W-1:0] i_rdata,
    output t_best             o_best
);

    logic                     r_found;
    logic [LIST_W-1:0]        r_idx;
    logic [HEAD_W-1:0]        r_head;
    logic signed [DATA_W-1:0] r_value;
    logic                     take;

    // Strict less-than keeps the lowest list index on ties
    assign take = i_cand.valid && (!r_found || ($signed(i_rdata) < r_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx   <= i_cand.idx;
            r_head  <= i_cand.head;
            r_value <= $signed(i_rdata);
        end
    end

    assign o_best.found = r_found;
    assign o_best.idx   = r_idx;
    assign o_best.head  = r_head;
    assign o_best.value = r_value;

endmodule

FILE: sv/k_way_sorted_merge_core.sv
// Top level of the k-way sorted merge core: sequencer, scan stage and result register.
//
//  channel | signals                              | payload
//  --------+--------------------------------------+---------------------------
//  input   | i_in_valid / o_in_ready / i_in_item  | mode, list_index, value
//  output  | o_out_valid / i_out_ready / o_out_item| result_value, status
//
// Append, clear and unused modes: the item goes from idle to the finish state, which commits the result.
// Pop: the scan state steps through the lists, one head per cycle from the element RAM into the single
// comparator; then the drain state and the finish state commit the result.
// i_rst_n is synchronous, active low; it empties all lists (RAM not cleared).
// The core accepts one item at a time; a result waits in the output register,
// and commit of the next item waits only while that register is still full.
module k_way_sorted_merge_core
    import kwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [LIST_W-1:0] r_scan, n_scan;
    t_cand             r_cand;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [LIST_W-1:0] rd_idx;
    logic [HEAD_W-1:0] fill_rd;
    logic [HEAD_W-1:0] head_rd;
    logic [DATA_W-1:0] rdata;
    t_ptr_cmd          ptr_cmd;
    t_best             best;
    logic              accept;
    logic              start;
    logic              out_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic              list_full;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign start      = accept;

    // Pointer tables are read at the scan slot while scanning, else at the item's list
    assign rd_idx = (r_state == ST_SCAN) ? r_scan : LIST_W'(r_item.list_index);

    assign list_full = (32'(r_item.list_index) >= LISTS) || (fill_rd == HEAD_W'(DEPTH));

    // RAM addressing: row per list, slot within row
    assign ram_raddr = {rd_idx, head_rd[SLOT_W-1:0]};
    assign ram_waddr = {LIST_W'(r_item.list_index), fill_rd[SLOT_W-1:0]};

    kwm_ptrs u_ptrs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .i_cmd    (ptr_cmd),
        .o_fill   (fill_rd),
        .o_head   (head_rd)
    );

    kwm_ram #(
        .WIDTH (DATA_W),
        .WORDS (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.value),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    kwm_minsel u_minsel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cand  (r_cand),
        .i_rdata (rdata),
        .o_best  (best)
    );

    // Control registers and the candidate that lines up with the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan       <= '0;
            r_out_valid  <= 1'b0;
            r_cand.valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan       <= n_scan;
            r_out_valid  <= n_out_valid;
            r_cand.valid <= (r_state == ST_SCAN) && (head_rd < fill_rd);
        end
        r_cand.idx  <= r_scan;
        r_cand.head <= head_rd;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        r_out <= n_out;
    end

    // Sequencer: next state, table updates and result
    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ptr_cmd     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_scan  = '0;
                    n_state = (i_in_item.mode == MODE_POP) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                if (r_scan == LIST_W'(LISTS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_scan = r_scan + LIST_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state                = ST_IDLE;
                    n_out_valid            = 1'b1;
                    n_out.result_value     = '0;
                    n_out.status           = STAT_OK;
                    case (r_item.mode)
                        MODE_APPEND: begin
                            if (list_full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                ram_we           = 1'b1;
                                ptr_cmd.fill_inc = 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (best.found) begin
                                n_out.result_value = best.value;
                                ptr_cmd.head_wr    = 1'b1;
                                ptr_cmd.head_idx   = best.idx;
                                ptr_cmd.head_val   = best.head + HEAD_W'(1);
                            end else begin
                                n_out.status = STAT_EMPTY;
                            end
                        end
                        MODE_CLEAR: begin
                            ptr_cmd.clear = 1'b1;
                        end
                        default: begin
                            n_out.status = STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
